FILE: design/cpfc_pkg.sv
// cpfc_pkg: shared widths, fixed-point constants and types for the
// cascaded PD flight controller; used by cpfc_serial_unit and the top level
package cpfc_pkg;

    // fixed-point format and field widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 20;
    localparam int ANG_W      = 20;
    localparam int OUT_W      = 17;
    localparam int NUM_GAINS  = 8;
    localparam int GIDX_W     = 3;
    localparam int NUM_LOOPS  = 5;
    localparam int LOOP_W     = 3;

    // serial arithmetic unit sizing
    localparam int MAG_W      = DATA_W + 1;          // magnitude of an error difference
    localparam int MUL_A_W    = DATA_W - 1;          // magnitude of a saturated value
    localparam int ACC_W      = MUL_A_W + GAIN_W;    // full product
    localparam int DIV_N_W    = MAG_W + FRAC_BITS;   // shifted dividend
    localparam int MUL_DIGIT  = 4;
    localparam int MUL_STEPS  = GAIN_W / MUL_DIGIT;
    localparam int DIV_STEPS  = DIV_N_W;
    localparam int CNT_W      = 6;

    // constants at 16 fraction bits
    localparam logic signed [ANG_W:0]  PI_Q      = 21'sd205887;
    localparam logic signed [ANG_W:0]  TWO_PI_Q  = 21'sd411774;
    localparam logic signed [DATA_W:0] LIM_HI    = 33'sd2147483647;
    localparam logic signed [DATA_W:0] ATT_LIM   = 33'sd22938;
    localparam logic signed [DATA_W:0] FLAP_LIM  = 33'sd34341;
    localparam logic signed [DATA_W:0] ONE_Q     = 33'sd65536;

    // gain register indexes
    localparam logic [GIDX_W-1:0] G_HEADING_KP  = 3'd0;
    localparam logic [GIDX_W-1:0] G_HEADING_KD  = 3'd1;
    localparam logic [GIDX_W-1:0] G_ALTITUDE_KP = 3'd2;
    localparam logic [GIDX_W-1:0] G_ALTITUDE_KD = 3'd3;
    localparam logic [GIDX_W-1:0] G_SPEED_KP    = 3'd4;
    localparam logic [GIDX_W-1:0] G_SPEED_KD    = 3'd5;
    localparam logic [GIDX_W-1:0] G_ATT_KP      = 3'd6;
    localparam logic [GIDX_W-1:0] G_ATT_KD      = 3'd7;

    // gain reset values
    localparam logic [GAIN_W-1:0] RST_HEADING_KP  = 20'd52429;
    localparam logic [GAIN_W-1:0] RST_HEADING_KD  = 20'd9830;
    localparam logic [GAIN_W-1:0] RST_ALTITUDE_KP = 20'd52429;
    localparam logic [GAIN_W-1:0] RST_ALTITUDE_KD = 20'd9830;
    localparam logic [GAIN_W-1:0] RST_SPEED_KP    = 20'd32768;
    localparam logic [GAIN_W-1:0] RST_SPEED_KD    = 20'd3277;
    localparam logic [GAIN_W-1:0] RST_ATT_KP      = 20'd78643;
    localparam logic [GAIN_W-1:0] RST_ATT_KD      = 20'd6554;

    // loop indexes
    localparam logic [LOOP_W-1:0] L_HEADING  = 3'd0;
    localparam logic [LOOP_W-1:0] L_ALTITUDE = 3'd1;
    localparam logic [LOOP_W-1:0] L_SPEED    = 3'd2;
    localparam logic [LOOP_W-1:0] L_ROLL     = 3'd3;
    localparam logic [LOOP_W-1:0] L_PITCH    = 3'd4;

    typedef enum logic {OP_MUL, OP_DIV} op_t;

    typedef struct packed {
        logic start;
        op_t  op;
        logic neg;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

FILE: design/cascaded_pid_flight_control.sv
// cascaded PD flight controller: five PD loops run one after another on one
// shared serial multiply/divide unit; each loop runs a multiply, a divide and a
// multiply in turn, the divider running 49 steps, and the output register is
// loaded after the last loop; a zero step time skips the loops and gives an all-zero
// result. next word is taken in the cycle after the result is in the output
// register, so only one word is in flight at a time; reset clears history, gains to defaults
module cascaded_pid_flight_control (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // target_heading, target_height, target_airspeed, measured_heading,
    // measured_height, measured_airspeed, measured_roll, measured_pitch, step_time
    input  logic [231:0]             s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // left_flap, right_flap, throttle
    output logic [55:0]              m_tdata,
    input  logic                     cfg_we,
    input  logic [cpfc_pkg::GIDX_W-1:0] cfg_addr,
    input  logic [cpfc_pkg::GAIN_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_P, ST_WAIT_P, ST_DIV, ST_WAIT_DIV, ST_MUL_D, ST_WAIT_D, ST_FIN
    } state_t;

    state_t                             state_reg;
    logic [cpfc_pkg::LOOP_W-1:0]        loop_reg;
    logic                               zero_reg;
    logic                               m_tvalid_reg;
    logic [55:0]                        m_tdata_reg;
    logic [cpfc_pkg::GAIN_W-1:0]        gain_reg [cpfc_pkg::NUM_GAINS];
    logic signed [cpfc_pkg::DATA_W-1:0] prev_reg [cpfc_pkg::NUM_LOOPS];

    logic signed [cpfc_pkg::ANG_W-1:0]  target_heading_reg;
    logic signed [cpfc_pkg::DATA_W-1:0] target_height_reg;
    logic signed [cpfc_pkg::DATA_W-1:0] target_airspeed_reg;
    logic signed [cpfc_pkg::ANG_W-1:0]  measured_heading_reg;
    logic signed [cpfc_pkg::DATA_W-1:0] measured_height_reg;
    logic signed [cpfc_pkg::DATA_W-1:0] measured_airspeed_reg;
    logic signed [cpfc_pkg::ANG_W-1:0]  measured_roll_reg;
    logic signed [cpfc_pkg::ANG_W-1:0]  measured_pitch_reg;
    logic [cpfc_pkg::GAIN_W-1:0]        step_time_reg;

    logic signed [15:0]                 roll_t_reg;
    logic signed [15:0]                 pitch_t_reg;
    logic signed [cpfc_pkg::DATA_W-1:0] thr_reg;
    logic signed [cpfc_pkg::DATA_W-1:0] roll_c_reg;
    logic signed [cpfc_pkg::DATA_W-1:0] pitch_c_reg;
    logic signed [cpfc_pkg::DATA_W-1:0] p_reg;
    logic signed [cpfc_pkg::DATA_W-1:0] dq_reg;

    logic                               accept;
    logic                               out_free;
    logic signed [cpfc_pkg::ANG_W:0]    head_diff;
    logic signed [cpfc_pkg::ANG_W:0]    head_wrap;
    logic signed [cpfc_pkg::ANG_W:0]    roll_diff;
    logic signed [cpfc_pkg::ANG_W:0]    pitch_diff;
    logic signed [cpfc_pkg::DATA_W:0]   hgt_diff;
    logic signed [cpfc_pkg::DATA_W:0]   spd_diff;
    logic signed [cpfc_pkg::DATA_W-1:0] e_cur;
    logic signed [cpfc_pkg::DATA_W:0]   e_diff;
    logic [cpfc_pkg::MAG_W-1:0]         e_mag;
    logic [cpfc_pkg::MAG_W-1:0]         diff_mag;
    logic [cpfc_pkg::MAG_W-1:0]         dq_mag;
    logic [cpfc_pkg::GIDX_W-1:0]        kp_idx;
    logic [cpfc_pkg::GIDX_W-1:0]        g_idx;
    cpfc_pkg::unit_req_t                ureq;
    cpfc_pkg::unit_stat_t               ustat;
    logic [cpfc_pkg::MAG_W-1:0]         umag;
    logic [cpfc_pkg::GAIN_W-1:0]        uk;
    logic signed [cpfc_pkg::DATA_W-1:0] ures;
    logic signed [cpfc_pkg::DATA_W:0]   loop_sum;
    logic signed [cpfc_pkg::DATA_W-1:0] loop_out;
    logic signed [15:0]                 att_clamped;
    logic signed [cpfc_pkg::DATA_W:0]   fl_sum;
    logic signed [cpfc_pkg::DATA_W:0]   fr_sum;
    logic [cpfc_pkg::OUT_W-1:0]         fl_q;
    logic [cpfc_pkg::OUT_W-1:0]         fr_q;
    logic [cpfc_pkg::OUT_W-1:0]         thr_q;

    // one wrap step toward plus or minus pi
    function automatic logic signed [cpfc_pkg::ANG_W:0] wrap_step(
        input logic signed [cpfc_pkg::ANG_W:0] a
    );
        logic signed [cpfc_pkg::ANG_W:0] r;
        r = a;
        if (a > cpfc_pkg::PI_Q)
        begin
            r = a - cpfc_pkg::TWO_PI_Q;
        end
        else if (a < -cpfc_pkg::PI_Q)
        begin
            r = a + cpfc_pkg::TWO_PI_Q;
        end
        return r;
    endfunction

    // symmetric saturation to the data width
    function automatic logic signed [cpfc_pkg::DATA_W-1:0] sat_w(
        input logic signed [cpfc_pkg::DATA_W:0] a
    );
        logic signed [cpfc_pkg::DATA_W:0] r;
        r = a;
        if (a > cpfc_pkg::LIM_HI)
        begin
            r = cpfc_pkg::LIM_HI;
        end
        else if (a < -cpfc_pkg::LIM_HI)
        begin
            r = -cpfc_pkg::LIM_HI;
        end
        return r[cpfc_pkg::DATA_W-1:0];
    endfunction

    // clamp to plus or minus a limit
    function automatic logic signed [cpfc_pkg::DATA_W:0] clamp_sym(
        input logic signed [cpfc_pkg::DATA_W:0] a,
        input logic signed [cpfc_pkg::DATA_W:0] lim
    );
        logic signed [cpfc_pkg::DATA_W:0] r;
        r = a;
        if (a > lim)
        begin
            r = lim;
        end
        else if (a < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // loop errors, full 20-bit heading difference needs up to three wrap steps
    assign head_diff  = $signed({target_heading_reg[cpfc_pkg::ANG_W-1], target_heading_reg})
                      - $signed({measured_heading_reg[cpfc_pkg::ANG_W-1], measured_heading_reg});
    assign head_wrap  = wrap_step(wrap_step(wrap_step(head_diff)));
    assign hgt_diff   = $signed({target_height_reg[cpfc_pkg::DATA_W-1], target_height_reg})
                      - $signed({measured_height_reg[cpfc_pkg::DATA_W-1], measured_height_reg});
    assign spd_diff   = $signed({target_airspeed_reg[cpfc_pkg::DATA_W-1], target_airspeed_reg})
                      - $signed({measured_airspeed_reg[cpfc_pkg::DATA_W-1], measured_airspeed_reg});
    assign roll_diff  = (cpfc_pkg::ANG_W+1)'(roll_t_reg)
                      - $signed({measured_roll_reg[cpfc_pkg::ANG_W-1], measured_roll_reg});
    assign pitch_diff = (cpfc_pkg::ANG_W+1)'(pitch_t_reg)
                      - $signed({measured_pitch_reg[cpfc_pkg::ANG_W-1], measured_pitch_reg});

    always_comb
    begin
        case (loop_reg)
            cpfc_pkg::L_HEADING:  e_cur = cpfc_pkg::DATA_W'(head_wrap);
            cpfc_pkg::L_ALTITUDE: e_cur = sat_w(hgt_diff);
            cpfc_pkg::L_SPEED:    e_cur = sat_w(spd_diff);
            cpfc_pkg::L_ROLL:     e_cur = cpfc_pkg::DATA_W'(roll_diff);
            default:              e_cur = cpfc_pkg::DATA_W'(pitch_diff);
        endcase
    end

    // magnitudes fed to the serial unit
    assign e_diff   = (cpfc_pkg::DATA_W+1)'(e_cur) - (cpfc_pkg::DATA_W+1)'(prev_reg[loop_reg]);
    assign e_mag    = e_cur[cpfc_pkg::DATA_W-1] ? -(cpfc_pkg::MAG_W'(e_cur)) : cpfc_pkg::MAG_W'(e_cur);
    assign diff_mag = e_diff[cpfc_pkg::DATA_W] ? -e_diff : e_diff;
    assign dq_mag   = dq_reg[cpfc_pkg::DATA_W-1] ? -(cpfc_pkg::MAG_W'(dq_reg))
                                                 : cpfc_pkg::MAG_W'(dq_reg);

    // gain select: kp in the proportional pass, kd in the derivative pass
    always_comb
    begin
        case (loop_reg)
            cpfc_pkg::L_HEADING:  kp_idx = cpfc_pkg::G_HEADING_KP;
            cpfc_pkg::L_ALTITUDE: kp_idx = cpfc_pkg::G_ALTITUDE_KP;
            cpfc_pkg::L_SPEED:    kp_idx = cpfc_pkg::G_SPEED_KP;
            default:              kp_idx = cpfc_pkg::G_ATT_KP;
        endcase
    end
    assign g_idx = {kp_idx[cpfc_pkg::GIDX_W-1:1], state_reg == ST_MUL_D};

    // serial unit request
    always_comb
    begin
        ureq = '{start: 1'b0, op: cpfc_pkg::OP_MUL, neg: 1'b0};
        umag = e_mag;
        uk   = gain_reg[g_idx];
        case (state_reg)
            ST_MUL_P:
            begin
                ureq = '{start: 1'b1, op: cpfc_pkg::OP_MUL, neg: e_cur[cpfc_pkg::DATA_W-1]};
            end
            ST_DIV:
            begin
                ureq = '{start: 1'b1, op: cpfc_pkg::OP_DIV, neg: e_diff[cpfc_pkg::DATA_W]};
                umag = diff_mag;
                uk   = step_time_reg;
            end
            ST_MUL_D:
            begin
                ureq = '{start: 1'b1, op: cpfc_pkg::OP_MUL, neg: dq_reg[cpfc_pkg::DATA_W-1]};
                umag = dq_mag;
            end
            default:
            begin
                ureq = '{start: 1'b0, op: cpfc_pkg::OP_MUL, neg: 1'b0};
            end
        endcase
    end

    cpfc_serial_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ureq),
        .mag    (umag),
        .k      (uk),
        .stat   (ustat),
        .result (ures)
    );

    // loop output and outer-loop clamp
    assign loop_sum    = (cpfc_pkg::DATA_W+1)'(p_reg) + (cpfc_pkg::DATA_W+1)'(ures);
    assign loop_out    = sat_w(loop_sum);
    assign att_clamped = 16'(clamp_sym((cpfc_pkg::DATA_W+1)'(loop_out), cpfc_pkg::ATT_LIM));

    // elevon mixing and throttle limit
    assign fl_sum = (cpfc_pkg::DATA_W+1)'(pitch_c_reg) + (cpfc_pkg::DATA_W+1)'(roll_c_reg);
    assign fr_sum = (cpfc_pkg::DATA_W+1)'(pitch_c_reg) - (cpfc_pkg::DATA_W+1)'(roll_c_reg);
    assign fl_q   = cpfc_pkg::OUT_W'(clamp_sym(fl_sum, cpfc_pkg::FLAP_LIM));
    assign fr_q   = cpfc_pkg::OUT_W'(clamp_sym(fr_sum, cpfc_pkg::FLAP_LIM));

    always_comb
    begin
        if (thr_reg[cpfc_pkg::DATA_W-1])
        begin
            thr_q = '0;
        end
        else if ((cpfc_pkg::DATA_W+1)'(thr_reg) > cpfc_pkg::ONE_Q)
        begin
            thr_q = cpfc_pkg::OUT_W'(cpfc_pkg::ONE_Q);
        end
        else
        begin
            thr_q = thr_reg[cpfc_pkg::OUT_W-1:0];
        end
    end

    // gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[cpfc_pkg::G_HEADING_KP]  <= cpfc_pkg::RST_HEADING_KP;
            gain_reg[cpfc_pkg::G_HEADING_KD]  <= cpfc_pkg::RST_HEADING_KD;
            gain_reg[cpfc_pkg::G_ALTITUDE_KP] <= cpfc_pkg::RST_ALTITUDE_KP;
            gain_reg[cpfc_pkg::G_ALTITUDE_KD] <= cpfc_pkg::RST_ALTITUDE_KD;
            gain_reg[cpfc_pkg::G_SPEED_KP]    <= cpfc_pkg::RST_SPEED_KP;
            gain_reg[cpfc_pkg::G_SPEED_KD]    <= cpfc_pkg::RST_SPEED_KD;
            gain_reg[cpfc_pkg::G_ATT_KP]      <= cpfc_pkg::RST_ATT_KP;
            gain_reg[cpfc_pkg::G_ATT_KD]      <= cpfc_pkg::RST_ATT_KD;
        end
        else if (cfg_we)
        begin
            gain_reg[cfg_addr] <= cfg_data;
        end
    end

    // sequencer, error history and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            loop_reg     <= '0;
            zero_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            for (int i = 0; i < cpfc_pkg::NUM_LOOPS; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            // a word leaving while no new one is loaded
            if (m_tvalid_reg && m_tready && state_reg != ST_FIN)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        loop_reg <= cpfc_pkg::L_HEADING;
                        zero_reg <= (s_tdata[227:208] == '0);
                        state_reg <= (s_tdata[227:208] == '0) ? ST_FIN : ST_MUL_P;
                    end
                end
                ST_MUL_P:    state_reg <= ST_WAIT_P;
                ST_WAIT_P:   if (ustat.done) state_reg <= ST_DIV;
                ST_DIV:      state_reg <= ST_WAIT_DIV;
                ST_WAIT_DIV: if (ustat.done) state_reg <= ST_MUL_D;
                ST_MUL_D:    state_reg <= ST_WAIT_D;
                ST_WAIT_D:
                begin
                    if (ustat.done)
                    begin
                        prev_reg[loop_reg] <= e_cur;
                        if (loop_reg == cpfc_pkg::L_PITCH)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            loop_reg  <= loop_reg + 1'b1;
                            state_reg <= ST_MUL_P;
                        end
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= zero_reg ? '0 : {5'b0, thr_q, fr_q, fl_q};
                        state_reg    <= ST_IDLE;
                    end
                    else if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // input capture and per-word working values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_heading_reg    <= s_tdata[19:0];
            target_height_reg     <= s_tdata[51:20];
            target_airspeed_reg   <= s_tdata[83:52];
            measured_heading_reg  <= s_tdata[103:84];
            measured_height_reg   <= s_tdata[135:104];
            measured_airspeed_reg <= s_tdata[167:136];
            measured_roll_reg     <= s_tdata[187:168];
            measured_pitch_reg    <= s_tdata[207:188];
            step_time_reg         <= s_tdata[227:208];
        end
        if (state_reg == ST_WAIT_P && ustat.done)
        begin
            p_reg <= ures;
        end
        if (state_reg == ST_WAIT_DIV && ustat.done)
        begin
            dq_reg <= ures;
        end
        if (state_reg == ST_WAIT_D && ustat.done)
        begin
            case (loop_reg)
                cpfc_pkg::L_HEADING:  roll_t_reg  <= att_clamped;
                cpfc_pkg::L_ALTITUDE: pitch_t_reg <= att_clamped;
                cpfc_pkg::L_SPEED:    thr_reg     <= loop_out;
                cpfc_pkg::L_ROLL:     roll_c_reg  <= loop_out;
                default:              pitch_c_reg <= loop_out;
            endcase
        end
    end

`ifndef SYNTHESIS
    // serial unit is never busy while a new word can be taken
    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ustat.busy)
        else $error("serial unit busy while idle");

    // unit completion only lands in a wait state
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ustat.done |-> (state_reg == ST_WAIT_P || state_reg == ST_WAIT_DIV
                        || state_reg == ST_WAIT_D))
        else $error("unit done outside wait state");

    // loop index stays within the five loops
    a_loop_range: assert property (@(posedge clk) disable iff (!rst_n)
        loop_reg <= cpfc_pkg::L_PITCH)
        else $error("loop index out of range");
`endif

endmodule

FILE: design/cpfc_serial_unit.sv
// cpfc_serial_unit: shared digit-serial multiplier (4 gain bits a cycle) and
// restoring divider (one quotient bit a cycle) with rounding and saturation
// depends on cpfc_pkg
module cpfc_serial_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cpfc_pkg::unit_req_t                req,
    input  logic [cpfc_pkg::MAG_W-1:0]         mag,
    input  logic [cpfc_pkg::GAIN_W-1:0]        k,
    output cpfc_pkg::unit_stat_t               stat,
    output logic signed [cpfc_pkg::DATA_W-1:0] result
);

    logic                               busy_reg;
    logic [cpfc_pkg::CNT_W-1:0]         cnt_reg;
    cpfc_pkg::op_t                      op_reg;
    logic                               neg_reg;
    logic [cpfc_pkg::ACC_W-1:0]         acc_reg;
    logic [cpfc_pkg::ACC_W-1:0]         mcand_reg;
    logic [cpfc_pkg::GAIN_W-1:0]        mplier_reg;
    logic [cpfc_pkg::GAIN_W-1:0]        divisor_reg;
    logic [cpfc_pkg::DIV_N_W-1:0]       work_reg;
    logic [cpfc_pkg::GAIN_W-1:0]        rem_reg;

    logic [cpfc_pkg::CNT_W-1:0]         last_cnt;
    logic                               done;
    logic                               step;
    logic [cpfc_pkg::ACC_W+cpfc_pkg::MUL_DIGIT-1:0] prod_full;
    logic [cpfc_pkg::GAIN_W:0]          trial;
    logic [cpfc_pkg::GAIN_W:0]          trial_sub;
    logic                               trial_ge;
    logic [cpfc_pkg::GAIN_W-1:0]        rem_next;
    logic [cpfc_pkg::ACC_W-cpfc_pkg::FRAC_BITS:0] mul_round;
    logic                               round_up;
    logic [cpfc_pkg::DIV_N_W:0]         div_round;
    logic                               mag_big;
    logic [cpfc_pkg::MUL_A_W-1:0]       mag_sat;
    logic signed [cpfc_pkg::DATA_W-1:0] mag_pos;

    // step control
    assign last_cnt = (op_reg == cpfc_pkg::OP_DIV) ? cpfc_pkg::CNT_W'(cpfc_pkg::DIV_STEPS)
                                                   : cpfc_pkg::CNT_W'(cpfc_pkg::MUL_STEPS);
    assign done = busy_reg && (cnt_reg == last_cnt);
    assign step = busy_reg && (cnt_reg != last_cnt);
    assign stat = '{busy: busy_reg, done: done};

    // multiply digit and divide trial subtract
    assign prod_full = mcand_reg * mplier_reg[cpfc_pkg::MUL_DIGIT-1:0];
    assign trial     = {rem_reg, work_reg[cpfc_pkg::DIV_N_W-1]};
    assign trial_sub = trial - {1'b0, divisor_reg};
    assign trial_ge  = trial >= {1'b0, divisor_reg};
    assign rem_next  = trial_ge ? trial_sub[cpfc_pkg::GAIN_W-1:0] : trial[cpfc_pkg::GAIN_W-1:0];

    // rounding, saturation and sign
    assign mul_round = {1'b0, acc_reg[cpfc_pkg::ACC_W-1:cpfc_pkg::FRAC_BITS]}
                     + (cpfc_pkg::ACC_W-cpfc_pkg::FRAC_BITS+1)'(acc_reg[cpfc_pkg::FRAC_BITS-1]);
    assign round_up  = {rem_reg, 1'b0} >= {1'b0, divisor_reg};
    assign div_round = {1'b0, work_reg} + (cpfc_pkg::DIV_N_W+1)'(round_up);

    always_comb
    begin
        if (op_reg == cpfc_pkg::OP_MUL)
        begin
            mag_big = mul_round > (cpfc_pkg::ACC_W-cpfc_pkg::FRAC_BITS+1)'(cpfc_pkg::LIM_HI);
            mag_sat = mul_round[cpfc_pkg::MUL_A_W-1:0];
        end
        else
        begin
            mag_big = div_round > (cpfc_pkg::DIV_N_W+1)'(cpfc_pkg::LIM_HI);
            mag_sat = div_round[cpfc_pkg::MUL_A_W-1:0];
        end
        if (mag_big)
        begin
            mag_sat = {cpfc_pkg::MUL_A_W{1'b1}};
        end
        mag_pos = $signed({1'b0, mag_sat});
        result  = neg_reg ? -mag_pos : mag_pos;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // operand and datapath registers
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            op_reg      <= req.op;
            neg_reg     <= req.neg;
            acc_reg     <= '0;
            mcand_reg   <= {{cpfc_pkg::GAIN_W{1'b0}}, mag[cpfc_pkg::MUL_A_W-1:0]};
            mplier_reg  <= k;
            divisor_reg <= k;
            work_reg    <= {mag, {cpfc_pkg::FRAC_BITS{1'b0}}};
            rem_reg     <= '0;
        end
        else if (step)
        begin
            if (op_reg == cpfc_pkg::OP_MUL)
            begin
                acc_reg    <= acc_reg + prod_full[cpfc_pkg::ACC_W-1:0];
                mcand_reg  <= mcand_reg << cpfc_pkg::MUL_DIGIT;
                mplier_reg <= mplier_reg >> cpfc_pkg::MUL_DIGIT;
            end
            else
            begin
                rem_reg  <= rem_next;
                work_reg <= {work_reg[cpfc_pkg::DIV_N_W-2:0], trial_ge};
            end
        end
    end

endmodule
